// File: rtl/core/sprd_pkg.sv
package sprd_pkg;

  // Header bytes that open a reply packet
  localparam logic [7:0] HdrFirst  = 8'hEF;
  localparam logic [7:0] HdrSecond = 8'h01;

  // Address bytes in a header, counted from zero
  localparam logic [15:0] AddrLastIdx = 16'd3;

  // Shortest legal length field: response code plus two checksum bytes
  localparam logic [15:0] MinLength = 16'd3;
  localparam logic [15:0] SumBytes  = 16'd2;

  // Kind of result item
  localparam logic KindBody = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // End of packet status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SUM_ERR   = 2'd1,
    ST_ADDR_ERR  = 2'd2,
    ST_SHORT_LEN = 2'd3
  } status_e;

  // Deframer phase, one-hot
  typedef enum logic [8:0] {
    PH_HUNT0 = 9'b0_0000_0001,
    PH_HUNT1 = 9'b0_0000_0010,
    PH_ADDR  = 9'b0_0000_0100,
    PH_ID    = 9'b0_0000_1000,
    PH_LENHI = 9'b0_0001_0000,
    PH_LENLO = 9'b0_0010_0000,
    PH_BODY  = 9'b0_0100_0000,
    PH_SUMHI = 9'b0_1000_0000,
    PH_SUMLO = 9'b1_0000_0000
  } phase_e;

  // One result item
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  packet_id;
    logic [7:0]  body_byte;
    logic [15:0] body_index;
    logic [15:0] packet_length;
    status_e     status;
    logic        last;
  } result_t;

endpackage

// File: rtl/core/sensor_reply_packet_deframer.sv
// A result is registered when its byte transfers: in the output register, or in the skid if full.
// Throughput: one byte per cycle; all per-byte work sits between the state registers and
// the output register. A skid register behind the output lets the input keep moving while
// a result waits; the input stalls only when both are full.
// Reset (asynchronous, active low): hunting for the header, output empty, device address all ones.
module sensor_reply_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  packet_id_o,
  output logic [7:0]  body_byte_o,
  output logic [15:0] body_index_o,
  output logic [15:0] packet_length_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import sprd_pkg::*;

  logic [31:0] dev_addr_q;
  phase_e      phase_q, phase_d;
  logic [31:0] addr_shift_q, addr_shift_d;
  logic [7:0]  pkt_id_q, pkt_id_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  sum_hi_q, sum_hi_d;
  logic        addr_ok_q, addr_ok_d;

  logic        in_xfer;
  logic        res_valid;
  result_t     res;
  logic [15:0] count_inc;
  logic [15:0] sum_add;
  logic [15:0] body_len;

  logic        out_valid_q, skid_valid_q;
  result_t     out_q, skid_q;
  logic        out_take;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '1;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i & ~skid_valid_q;

  assign count_inc = count_q + 16'd1;
  assign sum_add   = sum_q + {8'h00, rx_byte_i};
  assign body_len  = length_q - SumBytes;

  // Per-byte deframing
  always_comb begin
    phase_d      = phase_q;
    addr_shift_d = addr_shift_q;
    pkt_id_d     = pkt_id_q;
    length_d     = length_q;
    count_d      = count_q;
    sum_d        = sum_q;
    sum_hi_d     = sum_hi_q;
    addr_ok_d    = addr_ok_q;
    res_valid    = 1'b0;
    res          = '{item_kind: KindBody, packet_id: pkt_id_q, body_byte: 8'h00,
                     body_index: 16'h0000, packet_length: length_q, status: ST_OK,
                     last: 1'b0};
    unique case (phase_q)
      PH_HUNT1: begin
        if (rx_byte_i == HdrSecond) begin
          phase_d      = PH_ADDR;
          count_d      = '0;
          addr_shift_d = '0;
        end else if (rx_byte_i != HdrFirst) begin
          phase_d = PH_HUNT0;
        end
      end
      PH_ADDR: begin
        addr_shift_d = {addr_shift_q[23:0], rx_byte_i};
        count_d      = count_inc;
        if (count_q == AddrLastIdx) begin
          addr_ok_d = (addr_shift_d == dev_addr_q);
          phase_d   = PH_ID;
        end
      end
      PH_ID: begin
        pkt_id_d = rx_byte_i;
        sum_d    = {8'h00, rx_byte_i};
        phase_d  = PH_LENHI;
      end
      PH_LENHI: begin
        length_d = {rx_byte_i, 8'h00};
        sum_d    = sum_add;
        phase_d  = PH_LENLO;
      end
      PH_LENLO: begin
        length_d = {length_q[15:8], rx_byte_i};
        sum_d    = sum_add;
        count_d  = '0;
        if (length_d < MinLength) begin
          // too short for a body: close the packet at once
          phase_d           = PH_HUNT0;
          res_valid         = 1'b1;
          res.item_kind     = KindEnd;
          res.last          = 1'b1;
          res.packet_length = length_d;
          res.status        = addr_ok_q ? ST_SHORT_LEN : ST_ADDR_ERR;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        sum_d   = sum_add;
        count_d = count_inc;
        if (count_inc >= body_len) begin
          phase_d = PH_SUMHI;
        end
        res_valid      = addr_ok_q;
        res.body_byte  = rx_byte_i;
        res.body_index = count_q;
      end
      PH_SUMHI: begin
        sum_hi_d = rx_byte_i;
        phase_d  = PH_SUMLO;
      end
      PH_SUMLO: begin
        phase_d       = PH_HUNT0;
        res_valid     = 1'b1;
        res.item_kind = KindEnd;
        res.last      = 1'b1;
        if (!addr_ok_q) begin
          res.status = ST_ADDR_ERR;
        end else if ({sum_hi_q, rx_byte_i} != sum_q) begin
          res.status = ST_SUM_ERR;
        end else begin
          res.status = ST_OK;
        end
      end
      default: begin
        // hunting for the first header byte, also unused codes
        phase_d = (rx_byte_i == HdrFirst) ? PH_HUNT1 : PH_HUNT0;
      end
    endcase
  end

  // Deframer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT0;
      addr_shift_q <= '0;
      pkt_id_q     <= '0;
      length_q     <= '0;
      count_q      <= '0;
      sum_q        <= '0;
      sum_hi_q     <= '0;
      addr_ok_q    <= 1'b0;
    end else if (in_xfer) begin
      phase_q      <= phase_d;
      addr_shift_q <= addr_shift_d;
      pkt_id_q     <= pkt_id_d;
      length_q     <= length_d;
      count_q      <= count_d;
      sum_q        <= sum_d;
      sum_hi_q     <= sum_hi_d;
      addr_ok_q    <= addr_ok_d;
    end
  end

  // Output register with skid stage
  assign out_take = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_take) begin
      out_valid_q <= in_xfer & res_valid;
    end else if (in_xfer && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_take) begin
      if (in_xfer && res_valid) begin
        out_q <= res;
      end
    end else if (in_xfer && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign item_kind_o     = out_q.item_kind;
  assign packet_id_o     = out_q.packet_id;
  assign body_byte_o     = out_q.body_byte;
  assign body_index_o    = out_q.body_index;
  assign packet_length_o = out_q.packet_length;
  assign status_o        = out_q.status;
  assign last_o          = out_q.last;

endmodule

// File: rtl/core/sprd_checker.sv
module sprd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        item_kind_o,
  input logic [7:0]  body_byte_o,
  input logic [15:0] body_index_o,
  input logic [15:0] packet_length_o,
  input logic [1:0]  status_o,
  input logic        last_o
);
  import sprd_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // last marks exactly the end reports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == item_kind_o))
    else $error("last disagrees with item kind");

  // body transfers carry no status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KindBody |-> status_o == ST_OK)
    else $error("status set on body byte");

  // end reports carry zero byte and index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KindEnd |-> body_byte_o == 8'h00 && body_index_o == 16'h0000)
    else $error("end report carries body data");

  // body index stays inside the announced body
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KindBody
      |-> ({1'b0, body_index_o} + 17'd2) < {1'b0, packet_length_o})
    else $error("body index beyond length");

endmodule

bind sensor_reply_packet_deframer sprd_checker u_sprd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .item_kind_o     (item_kind_o),
  .body_byte_o     (body_byte_o),
  .body_index_o    (body_index_o),
  .packet_length_o (packet_length_o),
  .status_o        (status_o),
  .last_o          (last_o)
);

// File: test/sensor_reply_packet_deframer_tb.sv
module sensor_reply_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sprd_pkg::*;

  localparam int QuietLimit = 1000;  // cycles without any transfer before giving up
  localparam int HoldOff    = 4;     // settle time before a register write
  localparam int Tail       = 10;    // cycles watched after the last result

  // One row of the directed table: byte to send and, optionally, its typed-in result
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam int DirCount = 24;
  localparam dir_row_t DirRows [DirCount] = '{
    // broken header, then a repeated first header byte
    '{8'hEF, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{8'hEF, 1'b0, '0}, '{8'hEF, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    // matching address, length 2: short length report
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h07, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h02, 1'b1, '{KindEnd, 8'h07, 8'h00, 16'd0, 16'd2, ST_SHORT_LEN, 1'b1}},
    // shortest full packet, top body byte, wrong checksum
    '{8'hEF, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h03, 1'b0, '0},
    '{8'hFF, 1'b1, '{KindBody, 8'h80, 8'hFF, 16'd0, 16'd3, ST_OK, 1'b0}},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{KindEnd, 8'h80, 8'h00, 16'd0, 16'd3, ST_SUM_ERR, 1'b1}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        item_kind_o;
  logic [7:0]  packet_id_o;
  logic [7:0]  body_byte_o;
  logic [15:0] body_index_o;
  logic [15:0] packet_length_o;
  logic [1:0]  status_o;
  logic        last_o;

  // Side information travelling with each byte, sampled at its transfer
  logic        tag_typed;
  result_t     tag_want;

  // Deframer shadow state
  logic [31:0] dev_addr   = '1;
  phase_e      rx_state   = PH_HUNT0;
  logic [31:0] addr_acc   = '0;
  logic [7:0]  cur_id     = '0;
  logic [15:0] cur_len    = '0;
  logic [15:0] byte_cnt   = '0;
  logic [15:0] csum       = '0;
  logic [7:0]  csum_hi    = '0;
  logic        addr_ok    = 1'b0;

  result_t     expected_q [$];
  logic [7:0]  frame_q [$];
  int          outstanding  = 0;
  int          quiet_cycles = 0;
  int          fail_cnt     = 0;
  int          stall_left   = 0;
  logic        idle_on;
  logic [31:0] cfg_shadow   = '1;

  sensor_reply_packet_deframer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_kind_o     (item_kind_o),
    .packet_id_o     (packet_id_o),
    .body_byte_o     (body_byte_o),
    .body_index_o    (body_index_o),
    .packet_length_o (packet_length_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance the shadow deframer by one byte; emit is set when a result follows
  function automatic void deframe_byte(input logic [7:0] b, output bit emit,
                                       output result_t r);
    logic [15:0] idx;
    logic [15:0] recv;
    emit = 1'b0;
    r    = '0;
    r.packet_id = cur_id;
    case (rx_state)
      PH_HUNT1: begin
        if (b == HdrSecond) begin
          rx_state = PH_ADDR;
          byte_cnt = '0;
          addr_acc = '0;
        end else if (b != HdrFirst) begin
          rx_state = PH_HUNT0;
        end
      end
      PH_ADDR: begin
        addr_acc = {addr_acc[23:0], b};
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt > AddrLastIdx) begin
          addr_ok  = (addr_acc == dev_addr);
          rx_state = PH_ID;
        end
      end
      PH_ID: begin
        cur_id   = b;
        csum     = {8'h00, b};
        rx_state = PH_LENHI;
      end
      PH_LENHI: begin
        cur_len  = {b, 8'h00};
        csum     = csum + {8'h00, b};
        rx_state = PH_LENLO;
      end
      PH_LENLO: begin
        cur_len  = {cur_len[15:8], b};
        csum     = csum + {8'h00, b};
        byte_cnt = '0;
        if (cur_len < MinLength) begin
          // packet ends straight after the length field
          rx_state = PH_HUNT0;
          emit     = 1'b1;
          r = '{KindEnd, cur_id, 8'h00, 16'd0, cur_len,
                addr_ok ? ST_SHORT_LEN : ST_ADDR_ERR, 1'b1};
        end else begin
          rx_state = PH_BODY;
        end
      end
      PH_BODY: begin
        idx      = byte_cnt;
        csum     = csum + {8'h00, b};
        byte_cnt = byte_cnt + 16'd1;
        if (byte_cnt >= cur_len - SumBytes) rx_state = PH_SUMHI;
        if (addr_ok) begin
          emit = 1'b1;
          r    = '{KindBody, cur_id, b, idx, cur_len, ST_OK, 1'b0};
        end
      end
      PH_SUMHI: begin
        csum_hi  = b;
        rx_state = PH_SUMLO;
      end
      PH_SUMLO: begin
        recv     = {csum_hi, b};
        rx_state = PH_HUNT0;
        emit     = 1'b1;
        r = '{KindEnd, cur_id, 8'h00, 16'd0, cur_len,
              !addr_ok ? ST_ADDR_ERR : (recv != csum ? ST_SUM_ERR : ST_OK), 1'b1};
      end
      default: rx_state = (b == HdrFirst) ? PH_HUNT1 : PH_HUNT0;
    endcase
  endfunction

  // Append one reply packet to the frame queue
  function automatic void build_frame(input logic [31:0] addr, input logic [15:0] len,
                                      input bit sum_ok);
    logic [15:0] sum;
    logic [7:0]  id;
    logic [7:0]  d;
    int          i;
    id = 8'($urandom_range(0, 255));
    frame_q.push_back(HdrFirst);
    frame_q.push_back(HdrSecond);
    for (i = 3; i >= 0; i--) frame_q.push_back(addr[8*i +: 8]);
    frame_q.push_back(id);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    sum = {8'h00, id} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
    if (len >= MinLength) begin
      for (i = 0; i < int'(len) - 2; i++) begin
        // header bytes inside a body must not restart framing
        if ($urandom_range(0, 19) == 0) d = $urandom_range(0, 1) ? HdrFirst : HdrSecond;
        else d = 8'($urandom_range(0, 255));
        frame_q.push_back(d);
        sum = sum + {8'h00, d};
      end
      if (!sum_ok) sum = sum ^ 16'($urandom_range(1, 65535));
      frame_q.push_back(sum[15:8]);
      frame_q.push_back(sum[7:0]);
    end
  endfunction

  // Present one byte and hold it until its transfer
  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    tag_typed  <= typed;
    tag_want   <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_frame(input int from);
    int i;
    for (i = from; i < frame_q.size(); i++) send_byte(frame_q[i], 1'b0, '0);
  endtask

  // Stop sending and wait until every expected result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (HoldOff) @(posedge clk_i);
  endtask

  task automatic write_addr(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    cfg_shadow   = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random reply traffic: mostly well formed packets, some noise and cut-off packets
  task automatic run_traffic(input int n_bytes);
    int          sent;
    int          pick;
    int          cut;
    int          i;
    logic [31:0] addr;
    logic [15:0] len;
    sent = 0;
    while (sent < n_bytes) begin
      frame_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        if ($urandom_range(0, 1)) frame_q.push_back(HdrFirst);
        for (i = 0; i < $urandom_range(1, 4); i++) frame_q.push_back(8'($urandom_range(0, 255)));
        send_frame(0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 78) addr = cfg_shadow;
        else if (pick < 88) addr = cfg_shadow ^ (32'd1 << $urandom_range(0, 31));
        else addr = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 10) len = 16'($urandom_range(0, 2));
        else if (pick < 85) len = 16'($urandom_range(3, 24));
        else if (pick < 97) len = 16'($urandom_range(25, 300));
        else len = MinLength;
        if ($urandom_range(0, 1)) frame_q.push_back(HdrFirst);
        build_frame(addr, len, $urandom_range(0, 99) < 85);
        // cut-off packet: the rest of the stream is read as its continuation
        if ($urandom_range(0, 99) < 7) begin
          cut = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
        send_frame(0);
        sent += frame_q.size();
      end
    end
  endtask

  // Transfer monitor: shadow model, result check and output stall pattern
  always @(posedge clk_i) begin : monitor_p
    logic    in_x;
    logic    out_x;
    bit      has_res;
    result_t res;
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (cfg_we_i) dev_addr = cfg_wdata_i;
      in_x  = in_valid_i && !in_stall_o;
      out_x = out_valid_o && !out_stall_i;
      if (in_x) begin
        deframe_byte(rx_byte_i, has_res, res);
        if (tag_typed) expected_q.push_back(tag_want);
        else if (has_res) expected_q.push_back(res);
      end
      if (out_x) begin
        got = '{item_kind_o, packet_id_o, body_byte_o, body_index_o, packet_length_o,
                status_e'(status_o), last_o};
        if (expected_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: kind=%0d id=%02h byte=%02h idx=%0d len=%0d st=%0d",
                     got.item_kind, got.packet_id, got.body_byte, got.body_index,
                     got.packet_length, got.status);
        end else begin
          want = expected_q.pop_front();
          if (got.item_kind !== want.item_kind || got.packet_id !== want.packet_id ||
              got.body_byte !== want.body_byte || got.body_index !== want.body_index ||
              got.packet_length !== want.packet_length || got.status !== want.status ||
              got.last !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("mismatch exp: kind=%0d id=%02h byte=%02h idx=%0d len=%0d st=%0d last=%0d",
                       want.item_kind, want.packet_id, want.body_byte, want.body_index,
                       want.packet_length, want.status, want.last);
              $display("         got: kind=%0d id=%02h byte=%02h idx=%0d len=%0d st=%0d last=%0d",
                       got.item_kind, got.packet_id, got.body_byte, got.body_index,
                       got.packet_length, got.status, got.last);
            end
          end
        end
      end
      outstanding  <= expected_q.size();
      quiet_cycles <= (in_x || out_x || cfg_we_i) ? 0 : quiet_cycles + 1;
      // receiver stalls in bursts while idling is enabled
      if (stall_left != 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        stall_left   = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog_p
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus_p
    int          i;
    logic [31:0] mid_addr;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    rx_byte_i   <= '0;
    tag_typed   <= 1'b0;
    tag_want    <= '0;
    idle_on     <= 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset address
    for (i = 0; i < DirCount; i++) send_byte(DirRows[i].rx, DirRows[i].typed, DirRows[i].want);
    run_traffic(400);

    // address zero, including one longer packet
    drain();
    write_addr('0);
    run_traffic(200);
    frame_q.delete();
    build_frame('0, 16'd40, 1'b1);
    send_frame(0);
    run_traffic(200);

    // random address, a stretch without idling first
    drain();
    write_addr($urandom);
    idle_on <= 1'b0;
    run_traffic(150);
    idle_on <= 1'b1;
    run_traffic(250);

    // write lands halfway through an address; the fourth byte sees the new value
    mid_addr = '1;
    if (cfg_shadow == mid_addr) mid_addr = '0;
    frame_q.delete();
    build_frame(mid_addr, 16'($urandom_range(3, 12)), 1'b1);
    for (i = 0; i < 4; i++) send_byte(frame_q[i], 1'b0, '0);
    drain();
    write_addr(mid_addr);
    send_frame(4);

    // closing part without idling
    idle_on <= 1'b0;
    run_traffic(300);

    drain();
    repeat (Tail) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/sprd_pkg.sv
rtl/core/sensor_reply_packet_deframer.sv
rtl/core/sprd_checker.sv
test/sensor_reply_packet_deframer_tb.sv
